@@ rtl/fms_pkg.sv @@
// Shared types, constants and helper functions for the binary64 magnitude
// subtract pipeline. No dependencies.
package fms_pkg;

    localparam logic [63:0] HIDDEN_ALIGNED = 64'h4000_0000_0000_0000;
    localparam logic [10:0] EXP_MAX = 11'h7FF;
    localparam logic [9:0]  ROUND_HALF = 10'h200;
    localparam logic signed [12:0] EXP_OVF_EDGE = 13'sh7FD;

    // Stage 1 record: operands unpacked, ordered and aligned.
    typedef struct packed {
        logic        eq;
        logic        zero;
        logic        sign;
        logic [10:0] ez;
        logic [10:0] ea_m;
        logic [63:0] big;
        logic [63:0] small_sig;
        logic [51:0] diff;
    } s1_t;

    // Stage 2 record: raw difference and its leading-zero count.
    typedef struct packed {
        logic        eq;
        logic        zero;
        logic        sign;
        logic [10:0] ez;
        logic [10:0] ea_m;
        logic [63:0] val;
        logic [6:0]  lz;
    } s2_t;

    // Stage 3 record: either a finished result or a normalized value to round.
    typedef struct packed {
        logic        direct;
        logic        sign;
        logic [63:0] result;
        logic [63:0] rsig;
        logic [10:0] rexp;
        logic        chk_ovf;
        logic        force_inf;
    } s3_t;

    // Right shift that ORs every bit shifted out into the lowest bit.
    function automatic logic [63:0] sticky_shr(input logic [63:0] v, input logic [5:0] d);
        logic [63:0] lost;
        lost = v & ~({64{1'b1}} << d);
        return (v >> d) | {63'b0, (lost != 64'b0)};
    endfunction

    // Leading-zero count of a 64-bit word; 64 for zero.
    function automatic logic [6:0] lzc64(input logic [63:0] v);
        logic [6:0] n;
        n = 7'd64;
        for (int i = 0; i < 64; i++)
        begin
            if (v[i])
            begin
                n = 7'(63 - i);
            end
        end
        return n;
    endfunction

endpackage

@@ rtl/fms_align.sv @@
// Stage 1: unpacks the operands, orders them by exponent and aligns the
// smaller significand with a sticky right shift. Uses fms_pkg.
module fms_align
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic [63:0]    a_bits,
    input  logic [63:0]    b_bits,
    input  logic           result_sign,
    output logic           out_valid,
    output fms_pkg::s1_t   out_rec
);

    logic         valid_reg;
    fms_pkg::s1_t rec_reg;
    fms_pkg::s1_t rec_next;

    logic [10:0] ea;
    logic [10:0] eb;
    logic [51:0] fa;
    logic [51:0] fb;
    logic        a_gt;
    logic [10:0] e_big;
    logic [10:0] e_small;
    logic [51:0] f_big;
    logic [51:0] f_small;
    logic [10:0] exp_gap;
    logic [63:0] s_small;

    always_comb
    begin
        ea = a_bits[62:52];
        eb = b_bits[62:52];
        fa = a_bits[51:0];
        fb = b_bits[51:0];
        a_gt = (ea > eb);
        e_big = a_gt ? ea : eb;
        e_small = a_gt ? eb : ea;
        f_big = a_gt ? fa : fb;
        f_small = a_gt ? fb : fa;
        exp_gap = e_big - e_small;
        // A subnormal operand has no hidden bit and an effective exponent of one.
        if (e_small != 11'd0)
        begin
            s_small = {2'b0, f_small, 10'b0} | fms_pkg::HIDDEN_ALIGNED;
        end
        else
        begin
            s_small = {1'b0, f_small, 11'b0};
        end

        rec_next.eq = (ea == eb);
        rec_next.zero = (fa == fb);
        rec_next.ez = e_big;
        rec_next.ea_m = (ea != 11'd0) ? ea - 11'd1 : 11'd0;
        rec_next.diff = (fa >= fb) ? fa - fb : fb - fa;
        rec_next.big = {2'b0, f_big, 10'b0} | fms_pkg::HIDDEN_ALIGNED;
        if (exp_gap > 11'd63)
        begin
            rec_next.small_sig = {63'b0, (s_small != 64'b0)};
        end
        else
        begin
            rec_next.small_sig = fms_pkg::sticky_shr(s_small, exp_gap[5:0]);
        end
        if (ea == eb)
        begin
            rec_next.sign = result_sign ^ (fa < fb);
        end
        else
        begin
            rec_next.sign = result_sign ^ ~a_gt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

    assign out_valid = valid_reg;
    assign out_rec = rec_reg;

endmodule

@@ rtl/fms_diff_lzc.sv @@
// Stage 2: forms the significand difference and counts its leading zeros.
// Uses fms_pkg.
module fms_diff_lzc
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  fms_pkg::s1_t   in_rec,
    output logic           out_valid,
    output fms_pkg::s2_t   out_rec
);

    logic         valid_reg;
    fms_pkg::s2_t rec_reg;
    fms_pkg::s2_t rec_next;
    logic [63:0]  val;

    always_comb
    begin
        val = in_rec.eq ? {12'b0, in_rec.diff} : in_rec.big - in_rec.small_sig;
        rec_next.eq = in_rec.eq;
        rec_next.zero = in_rec.zero;
        rec_next.sign = in_rec.sign;
        rec_next.ez = in_rec.ez;
        rec_next.ea_m = in_rec.ea_m;
        rec_next.val = val;
        rec_next.lz = fms_pkg::lzc64(val);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

    assign out_valid = valid_reg;
    assign out_rec = rec_reg;

endmodule

@@ rtl/fms_norm.sv @@
// Stage 3: normalizes the difference, finishes exact results and prepares
// the rest for rounding, with sticky denormalization. Uses fms_pkg.
module fms_norm
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  fms_pkg::s2_t   in_rec,
    output logic           out_valid,
    output fms_pkg::s3_t   out_rec
);

    logic         valid_reg;
    fms_pkg::s3_t rec_reg;
    fms_pkg::s3_t rec_next;

    logic [6:0]         sd_e;
    logic signed [12:0] ez_e;
    logic [5:0]         sh_e;
    logic [10:0]        exp_e;
    logic [5:0]         sd;
    logic signed [12:0] expn;
    logic signed [12:0] neg_exp;
    logic [63:0]        sig2;

    always_comb
    begin
        sd_e = in_rec.lz - 7'd11;
        ez_e = $signed({2'b0, in_rec.ea_m}) - $signed({6'b0, sd_e});
        if (ez_e < 0)
        begin
            sh_e = in_rec.ea_m[5:0];
            exp_e = 11'd0;
        end
        else
        begin
            sh_e = sd_e[5:0];
            exp_e = ez_e[10:0];
        end

        sd = (in_rec.lz > 7'd63) ? 6'd62 : 6'(in_rec.lz - 7'd1);
        expn = $signed({2'b0, in_rec.ez}) - 13'sd1 - $signed({7'b0, sd});
        neg_exp = -expn;
        sig2 = in_rec.val << sd;

        rec_next.sign = in_rec.sign;
        rec_next.direct = 1'b1;
        rec_next.result = 64'b0;
        rec_next.rsig = sig2;
        rec_next.rexp = expn[10:0];
        rec_next.chk_ovf = (expn == fms_pkg::EXP_OVF_EDGE);
        rec_next.force_inf = (expn > fms_pkg::EXP_OVF_EDGE);

        if (in_rec.eq)
        begin
            if (!in_rec.zero)
            begin
                rec_next.result = {in_rec.sign, 63'b0} + {1'b0, exp_e, 52'b0}
                                  + (in_rec.val << sh_e);
            end
        end
        else if (sd >= 6'd10 && expn >= 0 && expn < fms_pkg::EXP_OVF_EDGE)
        begin
            // Enough leading zeros that the result is exact.
            rec_next.result = {in_rec.sign, 63'b0} + {1'b0, expn[10:0], 52'b0}
                              + (in_rec.val << (sd - 6'd10));
        end
        else
        begin
            rec_next.direct = 1'b0;
            if (expn < 0)
            begin
                rec_next.rsig = fms_pkg::sticky_shr(sig2, neg_exp[5:0]);
                rec_next.rexp = 11'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

    assign out_valid = valid_reg;
    assign out_rec = rec_reg;

endmodule

@@ rtl/fms_round.sv @@
// Stage 4: rounds to nearest even, detects overflow and packs the result.
// Uses fms_pkg.
module fms_round
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  fms_pkg::s3_t   in_rec,
    output logic           out_valid,
    output logic [63:0]    out_bits
);

    logic        valid_reg;
    logic [63:0] bits_reg;
    logic [63:0] bits_next;
    logic [63:0] sum;
    logic [53:0] rs;
    logic [10:0] rexp;

    always_comb
    begin
        sum = in_rec.rsig + {54'b0, fms_pkg::ROUND_HALF};
        rs = sum[63:10];
        // A tie clears the lowest bit.
        if (in_rec.rsig[9:0] == fms_pkg::ROUND_HALF)
        begin
            rs[0] = 1'b0;
        end
        rexp = (rs == 54'b0) ? 11'd0 : in_rec.rexp;
        if (in_rec.direct)
        begin
            bits_next = in_rec.result;
        end
        else if (in_rec.force_inf || (in_rec.chk_ovf && sum[63]))
        begin
            bits_next = {in_rec.sign, fms_pkg::EXP_MAX, 52'b0};
        end
        else
        begin
            bits_next = {in_rec.sign, 63'b0} + {1'b0, rexp, 52'b0} + {10'b0, rs};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        bits_reg <= bits_next;
    end

    assign out_valid = valid_reg;
    assign out_bits = bits_reg;

endmodule

@@ rtl/f64_magnitude_subtract_core.sv @@
// Binary64 magnitude subtract core: four-stage pipeline of align, subtract
// and leading-zero count, normalize, and round/pack. Uses fms_pkg.
// Throughput is one operation per cycle; busy is always low.
// Asynchronous active-low reset clears every stage valid bit.
module f64_magnitude_subtract_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] a_bits,
    input  logic [63:0] b_bits,
    input  logic        result_sign,
    output logic        done,
    output logic [63:0] diff_bits
);

    logic         v1;
    logic         v2;
    logic         v3;
    fms_pkg::s1_t r1;
    fms_pkg::s2_t r2;
    fms_pkg::s3_t r3;

    assign busy = 1'b0;

    fms_align u_align
    (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(start),
        .a_bits(a_bits),
        .b_bits(b_bits),
        .result_sign(result_sign),
        .out_valid(v1),
        .out_rec(r1)
    );

    fms_diff_lzc u_diff
    (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(v1),
        .in_rec(r1),
        .out_valid(v2),
        .out_rec(r2)
    );

    fms_norm u_norm
    (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(v2),
        .in_rec(r2),
        .out_valid(v3),
        .out_rec(r3)
    );

    fms_round u_round
    (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(v3),
        .in_rec(r3),
        .out_valid(done),
        .out_bits(diff_bits)
    );

endmodule
